### rtl/core/pmio_pkg.sv
// shared types, constants and functions of the port-mapped i/o controller
// used by every module under rtl/core but pmio_ram; depends on nothing
package pmio_pkg;

    // storage sizes
    localparam int TEXT_CELLS  = 2048;
    localparam int RING_DEPTH  = 256;
    localparam int BLOCK_BYTES = 512;
    localparam int QUEUE_DEPTH = 4;

    localparam int TEXT_AW  = $clog2(TEXT_CELLS);
    localparam int RING_AW  = $clog2(RING_DEPTH);
    localparam int BLOCK_AW = $clog2(BLOCK_BYTES);
    localparam int MEM_AW   = TEXT_AW;

    // pixel to text cell geometry
    localparam int PIX_ROW_BYTES = 320 * 8;
    localparam int CELL_COLS     = 80;

    // item operations
    typedef enum logic [2:0] {
        OP_WRITE  = 3'd0,
        OP_READ   = 3'd1,
        OP_KEY    = 3'd2,
        OP_SERIAL = 3'd3,
        OP_TICK   = 3'd4
    } op_t;

    // event kinds
    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_SER_TX    = 3'd1,
        EV_PIX_VIS   = 3'd2,
        EV_PIX_HID   = 3'd3,
        EV_CHAR      = 3'd4,
        EV_DISK_READ = 3'd5,
        EV_DISK_WR   = 3'd6
    } event_t;

    // port numbers
    localparam logic [7:0] PORT_SER_DATA  = 8'd1;
    localparam logic [7:0] PORT_SER_COUNT = 8'd2;
    localparam logic [7:0] PORT_SER_TX    = 8'd3;
    localparam logic [7:0] PORT_TEXT_ADDR = 8'd5;
    localparam logic [7:0] PORT_TEXT_DATA = 8'd6;
    localparam logic [7:0] PORT_KEY_DATA  = 8'd7;
    localparam logic [7:0] PORT_KEY_COUNT = 8'd8;
    localparam logic [7:0] PORT_PIX_ADDR  = 8'd9;
    localparam logic [7:0] PORT_PIX_DATA  = 8'd10;
    localparam logic [7:0] PORT_BLK_NUM   = 8'd14;
    localparam logic [7:0] PORT_BLK_DATA  = 8'd15;
    localparam logic [7:0] PORT_BLK_READ  = 8'd16;
    localparam logic [7:0] PORT_BLK_PUT   = 8'd17;
    localparam logic [7:0] PORT_BLK_WRITE = 8'd18;
    localparam logic [7:0] PORT_TIMER     = 8'd255;

    // key symbols that get remapped
    localparam logic [30:0] KEY_SYM_RIGHT = 31'd1073741903;
    localparam logic [30:0] KEY_SYM_LEFT  = 31'd1073741904;
    localparam logic [30:0] KEY_SYM_DOWN  = 31'd1073741905;
    localparam logic [30:0] KEY_SYM_UP    = 31'd1073741906;
    localparam logic [30:0] KEY_SYM_SHIFT = 31'd1073742049;
    localparam logic [30:0] KEY_SYM_ENTER = 31'd13;
    localparam logic [15:0] KEY_RELEASE_OFS = 16'h0100;

    // memory selected by a queued transaction
    typedef enum logic [2:0] {
        MEM_NONE   = 3'd0,
        MEM_TEXT   = 3'd1,
        MEM_KEY    = 3'd2,
        MEM_SERIAL = 3'd3,
        MEM_BLOCK  = 3'd4
    } mem_sel_t;

    // classified transaction between front and back
    typedef struct packed {
        mem_sel_t           mem;
        logic               mem_we;
        logic [MEM_AW-1:0]  mem_addr;
        logic [15:0]        mem_wdata;
        logic               use_rdata;
        logic               pix_check;
        logic [15:0]        read_data;
        event_t             event_kind;
        logic [15:0]        event_address;
        logic [7:0]         event_data;
        logic               timer_interrupt;
    } entry_t;

    // host key symbol to machine key code
    function automatic logic [15:0] map_key(input logic [30:0] sym, input logic rel);
        logic [15:0] code;
        code = sym[15:0];
        if (sym == KEY_SYM_LEFT)       code = 16'd28;
        else if (sym == KEY_SYM_UP)    code = 16'd29;
        else if (sym == KEY_SYM_RIGHT) code = 16'd30;
        else if (sym == KEY_SYM_DOWN)  code = 16'd31;
        else if (sym == KEY_SYM_SHIFT) code = 16'd16;
        else if (sym == KEY_SYM_ENTER) code = 16'd10;
        if (rel) code = code + KEY_RELEASE_OFS;
        return code;
    endfunction

    // quotient by five for values below 1024, reciprocal multiply
    function automatic logic [7:0] div5(input logic [9:0] x);
        logic [17:0] prod;
        prod = 18'(x) * 18'd205;
        return prod[17:10];
    endfunction

endpackage

### rtl/core/pmio_ram.sv
// generic single write, single read ram with registered read data
// depends on nothing
module pmio_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/pmio_fifo.sv
// short transaction queue between the front and the back
// depends on pmio_pkg
module pmio_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pmio_pkg::entry_t  push_entry,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output pmio_pkg::entry_t  head
);

    localparam int AW = $clog2(pmio_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(pmio_pkg::QUEUE_DEPTH + 1);

    pmio_pkg::entry_t slot_reg [pmio_pkg::QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign full      = (count_reg == CW'(pmio_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

endmodule

### rtl/core/pmio_front.sv
// front: accepts items, keeps the register state and classifies each
// item into a queued transaction; depends on pmio_pkg
module pmio_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        operation,
    input  logic [7:0]        port,
    input  logic [15:0]       value,
    input  logic [30:0]       key_code,
    input  logic              key_release,
    input  logic              clear_done,
    input  logic              q_full,
    output logic              push,
    output pmio_pkg::entry_t  push_entry
);

    logic [pmio_pkg::TEXT_AW-1:0]  text_addr_reg, text_addr_next;
    logic [15:0]                   pix_addr_reg, pix_addr_next;
    logic [pmio_pkg::RING_AW-1:0]  key_rd_reg, key_rd_next;
    logic [pmio_pkg::RING_AW-1:0]  key_wr_reg, key_wr_next;
    logic [pmio_pkg::RING_AW-1:0]  ser_rd_reg, ser_rd_next;
    logic [pmio_pkg::RING_AW-1:0]  ser_wr_reg, ser_wr_next;
    logic [15:0]                   blk_num_reg, blk_num_next;
    logic [pmio_pkg::BLOCK_AW-1:0] blk_ptr_reg, blk_ptr_next;
    logic [15:0]                   count_reg, count_next;
    logic                          armed_reg, armed_next;

    logic [7:0]  col_quot;
    logic [2:0]  col_rem;
    logic [6:0]  col;
    logic [4:0]  row;
    logic [11:0] cell_idx;
    logic [9:0]  pix_hi;
    logic [7:0]  row_quot;

    pmio_pkg::entry_t e;

    assign in_ready = !q_full && clear_done;
    assign push     = in_valid && in_ready;

    // covering text cell of the current pixel address
    always_comb
    begin
        pix_hi   = pix_addr_reg[15:6];
        col_quot = pmio_pkg::div5(pix_hi);
        col_rem  = 3'(10'(pix_hi) - 10'(col_quot) * 10'd5);
        col      = {col_rem, pix_addr_reg[5:2]};
        row_quot = pmio_pkg::div5({3'b000, pix_addr_reg[15:9]});
        row      = row_quot[4:0];
        cell_idx = 12'(col) + 12'(row) * 12'(pmio_pkg::CELL_COLS);
    end

    // classify and compute next register state
    always_comb
    begin
        text_addr_next = text_addr_reg;
        pix_addr_next  = pix_addr_reg;
        key_rd_next    = key_rd_reg;
        key_wr_next    = key_wr_reg;
        ser_rd_next    = ser_rd_reg;
        ser_wr_next    = ser_wr_reg;
        blk_num_next   = blk_num_reg;
        blk_ptr_next   = blk_ptr_reg;
        count_next     = count_reg;
        armed_next     = armed_reg;
        e              = '0;
        e.mem          = pmio_pkg::MEM_NONE;
        e.event_kind   = pmio_pkg::EV_NONE;

        unique case (operation)
            pmio_pkg::OP_WRITE:
            begin
                unique case (port)
                    pmio_pkg::PORT_SER_DATA: ser_rd_next = ser_rd_reg + 1'b1;
                    pmio_pkg::PORT_SER_TX:
                    begin
                        e.event_kind = pmio_pkg::EV_SER_TX;
                        e.event_data = value[7:0];
                    end
                    pmio_pkg::PORT_TEXT_ADDR: text_addr_next = value[pmio_pkg::TEXT_AW-1:0];
                    pmio_pkg::PORT_TEXT_DATA:
                    begin
                        e.mem           = pmio_pkg::MEM_TEXT;
                        e.mem_we        = 1'b1;
                        e.mem_addr      = text_addr_reg;
                        e.mem_wdata     = {8'd0, value[7:0]};
                        e.event_kind    = pmio_pkg::EV_CHAR;
                        e.event_address = 16'(text_addr_reg);
                        e.event_data    = value[7:0];
                    end
                    pmio_pkg::PORT_PIX_ADDR: pix_addr_next = value;
                    pmio_pkg::PORT_PIX_DATA:
                    begin
                        e.event_address = pix_addr_reg;
                        e.event_data    = value[7:0];
                        if (cell_idx < 12'(pmio_pkg::TEXT_CELLS))
                        begin
                            e.mem       = pmio_pkg::MEM_TEXT;
                            e.mem_addr  = cell_idx[pmio_pkg::TEXT_AW-1:0];
                            e.pix_check = 1'b1;
                        end
                        else
                        begin
                            e.event_kind = pmio_pkg::EV_PIX_VIS;
                        end
                    end
                    pmio_pkg::PORT_BLK_NUM:  blk_num_next = value;
                    pmio_pkg::PORT_BLK_DATA: blk_ptr_next = blk_ptr_reg + 1'b1;
                    pmio_pkg::PORT_BLK_READ:
                    begin
                        blk_ptr_next    = '0;
                        e.event_kind    = pmio_pkg::EV_DISK_READ;
                        e.event_address = blk_num_reg;
                    end
                    pmio_pkg::PORT_BLK_PUT:
                    begin
                        e.mem        = pmio_pkg::MEM_BLOCK;
                        e.mem_we     = 1'b1;
                        e.mem_addr   = pmio_pkg::MEM_AW'(blk_ptr_reg);
                        e.mem_wdata  = {8'd0, value[7:0]};
                        blk_ptr_next = blk_ptr_reg + 1'b1;
                    end
                    pmio_pkg::PORT_BLK_WRITE:
                    begin
                        blk_ptr_next    = '0;
                        e.event_kind    = pmio_pkg::EV_DISK_WR;
                        e.event_address = blk_num_reg;
                    end
                    pmio_pkg::PORT_TIMER:
                    begin
                        armed_next = 1'b1;
                        count_next = value;
                    end
                    default: ;
                endcase
            end
            pmio_pkg::OP_READ:
            begin
                unique case (port) inside
                    pmio_pkg::PORT_SER_DATA:
                    begin
                        e.mem       = pmio_pkg::MEM_SERIAL;
                        e.mem_addr  = pmio_pkg::MEM_AW'(ser_rd_reg);
                        e.use_rdata = 1'b1;
                    end
                    pmio_pkg::PORT_SER_COUNT: e.read_data = {8'd0, ser_wr_reg - ser_rd_reg};
                    pmio_pkg::PORT_TEXT_DATA:
                    begin
                        e.mem       = pmio_pkg::MEM_TEXT;
                        e.mem_addr  = text_addr_reg;
                        e.use_rdata = 1'b1;
                    end
                    pmio_pkg::PORT_KEY_DATA:
                    begin
                        e.mem       = pmio_pkg::MEM_KEY;
                        e.mem_addr  = pmio_pkg::MEM_AW'(key_rd_reg);
                        e.use_rdata = 1'b1;
                        key_rd_next = key_rd_reg + 1'b1;
                    end
                    pmio_pkg::PORT_KEY_COUNT: e.read_data = {8'd0, key_wr_reg - key_rd_reg};
                    pmio_pkg::PORT_BLK_DATA:
                    begin
                        e.mem       = pmio_pkg::MEM_BLOCK;
                        e.mem_addr  = pmio_pkg::MEM_AW'(blk_ptr_reg);
                        e.use_rdata = 1'b1;
                    end
                    pmio_pkg::PORT_BLK_READ, pmio_pkg::PORT_BLK_WRITE:
                        e.read_data = 16'(blk_ptr_reg);
                    default: ;
                endcase
            end
            pmio_pkg::OP_KEY:
            begin
                e.mem       = pmio_pkg::MEM_KEY;
                e.mem_we    = 1'b1;
                e.mem_addr  = pmio_pkg::MEM_AW'(key_wr_reg);
                e.mem_wdata = pmio_pkg::map_key(key_code, key_release);
                key_wr_next = key_wr_reg + 1'b1;
            end
            pmio_pkg::OP_SERIAL:
            begin
                e.mem       = pmio_pkg::MEM_SERIAL;
                e.mem_we    = 1'b1;
                e.mem_addr  = pmio_pkg::MEM_AW'(ser_wr_reg);
                e.mem_wdata = {8'd0, value[7:0]};
                ser_wr_next = ser_wr_reg + 1'b1;
            end
            pmio_pkg::OP_TICK:
            begin
                if (armed_reg)
                begin
                    count_next = count_reg - 16'd1;
                    if (count_reg == 16'd1)
                    begin
                        armed_next        = 1'b0;
                        e.timer_interrupt = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign push_entry = e;

    // register state, updated on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_addr_reg <= '0;
            pix_addr_reg  <= '0;
            key_rd_reg    <= '0;
            key_wr_reg    <= '0;
            ser_rd_reg    <= '0;
            ser_wr_reg    <= '0;
            blk_num_reg   <= '0;
            blk_ptr_reg   <= '0;
            count_reg     <= '0;
            armed_reg     <= 1'b0;
        end
        else if (push)
        begin
            text_addr_reg <= text_addr_next;
            pix_addr_reg  <= pix_addr_next;
            key_rd_reg    <= key_rd_next;
            key_wr_reg    <= key_wr_next;
            ser_rd_reg    <= ser_rd_next;
            ser_wr_reg    <= ser_wr_next;
            blk_num_reg   <= blk_num_next;
            blk_ptr_reg   <= blk_ptr_next;
            count_reg     <= count_next;
            armed_reg     <= armed_next;
        end
    end

endmodule

### rtl/core/pmio_back.sv
// back: carries out queued transactions on the memories and holds the
// result register; clears the text memory after reset. depends on
// pmio_pkg and pmio_ram
module pmio_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_not_empty,
    input  pmio_pkg::entry_t  q_head,
    output logic              pop,
    output logic              clear_done,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [15:0]       read_data,
    output logic [2:0]        event_kind,
    output logic [15:0]       event_address,
    output logic [7:0]        event_data,
    output logic              timer_interrupt
);

    localparam int CW = pmio_pkg::TEXT_AW + 1;

    logic [CW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic             clear_done_reg;
    logic             s2_valid_reg, s2_valid_next;
    pmio_pkg::entry_t s2_reg;
    logic             out_valid_reg, out_valid_next;
    logic [15:0]      rd_reg;
    logic [2:0]       kind_reg;
    logic [15:0]      addr_reg;
    logic [7:0]       data_reg;
    logic             irq_reg;
    logic             move;

    logic        text_we, text_re, key_we, key_re, ser_we, ser_re, blk_we, blk_re;
    logic [pmio_pkg::TEXT_AW-1:0] text_waddr;
    logic [7:0]  text_wdata;
    logic [7:0]  text_dout, ser_dout, blk_dout;
    logic [15:0] key_dout;
    logic [15:0] mem_dout;
    logic [2:0]  kind_sel;

    assign clear_done = clear_done_reg;

    // text memory clearing pass after reset
    always_comb
    begin
        clr_cnt_next = clear_done_reg ? clr_cnt_reg : clr_cnt_reg + CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg    <= '0;
            clear_done_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            if (clr_cnt_reg == CW'(pmio_pkg::TEXT_CELLS - 1))
            begin
                clear_done_reg <= 1'b1;
            end
        end
    end

    // pipeline advance
    assign move = s2_valid_reg && (!out_valid_reg || out_ready);
    assign pop  = q_not_empty && clear_done_reg && (!s2_valid_reg || move);

    // memory strobes
    always_comb
    begin
        text_we = pop && q_head.mem_we && (q_head.mem == pmio_pkg::MEM_TEXT);
        text_re = pop && !q_head.mem_we && (q_head.mem == pmio_pkg::MEM_TEXT);
        key_we  = pop && q_head.mem_we && (q_head.mem == pmio_pkg::MEM_KEY);
        key_re  = pop && !q_head.mem_we && (q_head.mem == pmio_pkg::MEM_KEY);
        ser_we  = pop && q_head.mem_we && (q_head.mem == pmio_pkg::MEM_SERIAL);
        ser_re  = pop && !q_head.mem_we && (q_head.mem == pmio_pkg::MEM_SERIAL);
        blk_we  = pop && q_head.mem_we && (q_head.mem == pmio_pkg::MEM_BLOCK);
        blk_re  = pop && !q_head.mem_we && (q_head.mem == pmio_pkg::MEM_BLOCK);
        if (!clear_done_reg)
        begin
            text_waddr = clr_cnt_reg[pmio_pkg::TEXT_AW-1:0];
            text_wdata = '0;
        end
        else
        begin
            text_waddr = q_head.mem_addr;
            text_wdata = q_head.mem_wdata[7:0];
        end
    end

    pmio_ram #(.WIDTH(8), .DEPTH(pmio_pkg::TEXT_CELLS)) u_text_ram (
        .clk   (clk),
        .we    (text_we || !clear_done_reg),
        .waddr (text_waddr),
        .wdata (text_wdata),
        .re    (text_re),
        .raddr (q_head.mem_addr),
        .rdata (text_dout)
    );

    pmio_ram #(.WIDTH(16), .DEPTH(pmio_pkg::RING_DEPTH)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (q_head.mem_addr[pmio_pkg::RING_AW-1:0]),
        .wdata (q_head.mem_wdata),
        .re    (key_re),
        .raddr (q_head.mem_addr[pmio_pkg::RING_AW-1:0]),
        .rdata (key_dout)
    );

    pmio_ram #(.WIDTH(8), .DEPTH(pmio_pkg::RING_DEPTH)) u_serial_ram (
        .clk   (clk),
        .we    (ser_we),
        .waddr (q_head.mem_addr[pmio_pkg::RING_AW-1:0]),
        .wdata (q_head.mem_wdata[7:0]),
        .re    (ser_re),
        .raddr (q_head.mem_addr[pmio_pkg::RING_AW-1:0]),
        .rdata (ser_dout)
    );

    pmio_ram #(.WIDTH(8), .DEPTH(pmio_pkg::BLOCK_BYTES)) u_block_ram (
        .clk   (clk),
        .we    (blk_we),
        .waddr (q_head.mem_addr[pmio_pkg::BLOCK_AW-1:0]),
        .wdata (q_head.mem_wdata[7:0]),
        .re    (blk_re),
        .raddr (q_head.mem_addr[pmio_pkg::BLOCK_AW-1:0]),
        .rdata (blk_dout)
    );

    // read data select for the transaction in the memory stage
    always_comb
    begin
        case (s2_reg.mem)
            pmio_pkg::MEM_TEXT:   mem_dout = {8'd0, text_dout};
            pmio_pkg::MEM_KEY:    mem_dout = key_dout;
            pmio_pkg::MEM_SERIAL: mem_dout = {8'd0, ser_dout};
            pmio_pkg::MEM_BLOCK:  mem_dout = {8'd0, blk_dout};
            default:              mem_dout = '0;
        endcase
        if (!s2_reg.pix_check)
        begin
            kind_sel = s2_reg.event_kind;
        end
        else if (text_dout != 8'd0)
        begin
            kind_sel = pmio_pkg::EV_PIX_HID;
        end
        else
        begin
            kind_sel = pmio_pkg::EV_PIX_VIS;
        end
    end

    // stage valid flags
    always_comb
    begin
        s2_valid_next  = pop ? 1'b1 : (move ? 1'b0 : s2_valid_reg);
        out_valid_next = move ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // memory stage and result register payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s2_reg <= q_head;
        end
        if (move)
        begin
            rd_reg   <= s2_reg.use_rdata ? mem_dout : s2_reg.read_data;
            kind_reg <= kind_sel;
            addr_reg <= s2_reg.event_address;
            data_reg <= s2_reg.event_data;
            irq_reg  <= s2_reg.timer_interrupt;
        end
    end

    assign out_valid       = out_valid_reg;
    assign read_data       = rd_reg;
    assign event_kind      = kind_reg;
    assign event_address   = addr_reg;
    assign event_data      = data_reg;
    assign timer_interrupt = irq_reg;

`ifndef SYNTH
    a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> clear_done_reg)
        else $error("transaction popped during text clearing");

    a_stage_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && s2_valid_reg) |-> move)
        else $error("memory stage overwritten while held");

    a_empty_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        !clear_done_reg |-> (!s2_valid_reg && !out_valid_reg))
        else $error("result pending during text clearing");

    a_clear_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        clear_done_reg |=> clear_done_reg)
        else $error("clearing restarted without reset");
`endif

endmodule

### rtl/core/port_mapped_io_controller_top.sv
// path: an accepted transaction passes through the queue, the memory stage and the
// result register; throughput: one transaction per cycle while out_ready does not stall,
// one memory access per ram port; reset: asynchronous active low; afterwards a clearing
// pass over all 2048 text cells runs, one cell per cycle; in_ready stays low until it ends
// top level: front, transaction queue, back; depends on pmio_pkg and all pmio modules
module port_mapped_io_controller_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [7:0]  port,
    input  logic [15:0] value,
    input  logic [30:0] key_code,
    input  logic        key_release,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] read_data,
    output logic [2:0]  event_kind,
    output logic [15:0] event_address,
    output logic [7:0]  event_data,
    output logic        timer_interrupt
);

    logic             push, pop, q_full, q_not_empty, clear_done;
    pmio_pkg::entry_t push_entry, q_head;

    // classify accepted transactions
    pmio_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .port        (port),
        .value       (value),
        .key_code    (key_code),
        .key_release (key_release),
        .clear_done  (clear_done),
        .q_full      (q_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    // decoupling queue
    pmio_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    // execute on memories and deliver results
    pmio_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_not_empty     (q_not_empty),
        .q_head          (q_head),
        .pop             (pop),
        .clear_done      (clear_done),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .read_data       (read_data),
        .event_kind      (event_kind),
        .event_address   (event_address),
        .event_data      (event_data),
        .timer_interrupt (timer_interrupt)
    );

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for port_mapped_io_controller_top: random and directed
// port transactions checked against a local predictor; depends on pmio_pkg and the rtl
module tb;
    import pmio_pkg::*;

    typedef struct packed {
        logic [15:0] read_data;
        logic [2:0]  event_kind;
        logic [15:0] event_address;
        logic [7:0]  event_data;
        logic        timer_interrupt;
    } io_result_t;

    // predictor of the i/o controller plus queue of expected results
    class io_scoreboard;
        logic [7:0]  text_mem [TEXT_CELLS];
        logic [15:0] key_mem [RING_DEPTH];
        logic [7:0]  ser_mem [RING_DEPTH];
        logic [7:0]  blk_mem [BLOCK_BYTES];
        logic [10:0] text_addr;
        logic [15:0] pix_addr;
        logic [7:0]  key_rd, key_wr, ser_rd, ser_wr;
        logic [15:0] blk_num;
        logic [8:0]  blk_ptr;
        logic [15:0] count;
        logic        armed;
        io_result_t  pending [$];
        int          errors;

        function new();
            foreach (text_mem[i]) text_mem[i] = 0;
            foreach (key_mem[i]) key_mem[i] = 0;
            foreach (ser_mem[i]) ser_mem[i] = 0;
            foreach (blk_mem[i]) blk_mem[i] = 0;
            text_addr = 0; pix_addr = 0; key_rd = 0; key_wr = 0; ser_rd = 0; ser_wr = 0;
            blk_num = 0; blk_ptr = 0; count = 0; armed = 0; errors = 0;
        endfunction

        function logic [15:0] remap(logic [30:0] sym, logic rel);
            logic [15:0] c;
            case (sym)
                KEY_SYM_LEFT:  c = 28;
                KEY_SYM_UP:    c = 29;
                KEY_SYM_RIGHT: c = 30;
                KEY_SYM_DOWN:  c = 31;
                KEY_SYM_SHIFT: c = 16;
                KEY_SYM_ENTER: c = 10;
                default:       c = sym[15:0];
            endcase
            return rel ? c + KEY_RELEASE_OFS : c;
        endfunction

        function void note_input(logic [2:0] op, logic [7:0] p, logic [15:0] v,
                                 logic [30:0] sym, logic rel);
            io_result_t r;
            int cell_idx;
            r = '0;
            if (op == OP_WRITE) begin
                case (p)
                    PORT_SER_DATA:  ser_rd++;
                    PORT_SER_TX:    begin r.event_kind = EV_SER_TX; r.event_data = v[7:0]; end
                    PORT_TEXT_ADDR: text_addr = v[10:0];
                    PORT_TEXT_DATA: begin
                        text_mem[text_addr] = v[7:0];
                        r.event_kind = EV_CHAR; r.event_address = 16'(text_addr);
                        r.event_data = v[7:0];
                    end
                    PORT_PIX_ADDR:  pix_addr = v;
                    PORT_PIX_DATA:  begin
                        cell_idx = (int'(pix_addr) % 320) / 4 + (int'(pix_addr) / 2560) * 80;
                        r.event_kind = (cell_idx < TEXT_CELLS && text_mem[cell_idx] != 0)
                                       ? EV_PIX_HID : EV_PIX_VIS;
                        r.event_address = pix_addr; r.event_data = v[7:0];
                    end
                    PORT_BLK_NUM:   blk_num = v;
                    PORT_BLK_DATA:  blk_ptr++;
                    PORT_BLK_READ:  begin
                        blk_ptr = 0; r.event_kind = EV_DISK_READ; r.event_address = blk_num;
                    end
                    PORT_BLK_PUT:   begin blk_mem[blk_ptr] = v[7:0]; blk_ptr++; end
                    PORT_BLK_WRITE: begin
                        blk_ptr = 0; r.event_kind = EV_DISK_WR; r.event_address = blk_num;
                    end
                    PORT_TIMER:     begin armed = 1; count = v; end
                    default: ;
                endcase
            end else if (op == OP_READ) begin
                case (p)
                    PORT_SER_DATA:  r.read_data = 16'(ser_mem[ser_rd]);
                    PORT_SER_COUNT: r.read_data = 16'(8'(ser_wr - ser_rd));
                    PORT_TEXT_DATA: r.read_data = 16'(text_mem[text_addr]);
                    PORT_KEY_DATA:  begin r.read_data = key_mem[key_rd]; key_rd++; end
                    PORT_KEY_COUNT: r.read_data = 16'(8'(key_wr - key_rd));
                    PORT_BLK_DATA:  r.read_data = 16'(blk_mem[blk_ptr]);
                    PORT_BLK_READ, PORT_BLK_WRITE: r.read_data = 16'(blk_ptr);
                    default: ;
                endcase
            end else if (op == OP_KEY) begin
                key_mem[key_wr] = remap(sym, rel); key_wr++;
            end else if (op == OP_SERIAL) begin
                ser_mem[ser_wr] = v[7:0]; ser_wr++;
            end else if (op == OP_TICK && armed) begin
                count--;
                if (count == 0) begin armed = 0; r.timer_interrupt = 1; end
            end
            pending.push_back(r);
        endfunction

        function void check_result(io_result_t got);
            io_result_t exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.read_data !== exp.read_data)
                $display("%0t: read_data exp %h got %h", $time, exp.read_data, got.read_data);
            if (got.event_kind !== exp.event_kind)
                $display("%0t: event_kind exp %0d got %0d", $time, exp.event_kind,
                         got.event_kind);
            if (got.event_address !== exp.event_address)
                $display("%0t: event_address exp %h got %h", $time, exp.event_address,
                         got.event_address);
            if (got.event_data !== exp.event_data)
                $display("%0t: event_data exp %h got %h", $time, exp.event_data, got.event_data);
            if (got.timer_interrupt !== exp.timer_interrupt)
                $display("%0t: timer_interrupt exp %b got %b", $time, exp.timer_interrupt,
                         got.timer_interrupt);
            if (got !== exp) errors++;
        endfunction
    endclass

    logic        clk = 0, rst_n = 0;
    logic        in_valid = 0, in_ready, out_valid, out_ready = 0;
    logic [2:0]  operation = 0;
    logic [7:0]  port = 0;
    logic [15:0] value = 0;
    logic [30:0] key_code = 0;
    logic        key_release = 0;
    logic [15:0] read_data, event_address;
    logic [2:0]  event_kind;
    logic [7:0]  event_data;
    logic        timer_interrupt;

    io_scoreboard sb = new();
    bit  sending_done = 0;
    bit  long_hold = 0;
    int  idle_cycles = 0;
    // keys and serial bytes known written, so reads stay on written entries
    int  keys_held = 0, ser_held = 0;
    bit  blk_written [BLOCK_BYTES];
    logic [8:0] blk_ptr_tb = 0;

    port_mapped_io_controller_top dut (.*);

    always begin
        #2 clk = 1;
        #2 clk = 0;
    end

    // sample results at the edge
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result({read_data, event_kind, event_address, event_data,
                             timer_interrupt});

    // watchdog on cycles with no transaction
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("FAIL port_mapped_io_controller_top");
            $finish;
        end
    end

    // receiver with random stalls
    initial begin
        int w;
        @(posedge rst_n);
        forever begin
            if (long_hold) begin
                out_ready <= 0;
                repeat (300) @(posedge clk);
                long_hold = 0;
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if ($urandom_range(0, 2) == 0) w = 0;
            if (w > 0) begin
                out_ready <= 0;
                repeat (w) @(posedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
            while (!(out_valid && out_ready)) @(posedge clk);
        end
    end

    task automatic send(logic [2:0] op, logic [7:0] p, logic [15:0] v,
                        logic [30:0] sym, logic rel, int gap);
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1; operation <= op; port <= p; value <= v;
        key_code <= sym; key_release <= rel;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(op, p, v, sym, rel);
    endtask

    // random draw of a transaction, unused ports and operations included, avoiding unwritten reads
    task automatic send_random(int gap);
        logic [2:0]  op;
        logic [7:0]  p;
        logic [15:0] v;
        logic [30:0] sym;
        int k;
        logic [7:0] wports [15] = '{PORT_SER_DATA, PORT_SER_TX, PORT_TEXT_ADDR,
            PORT_TEXT_DATA, PORT_PIX_ADDR, PORT_PIX_DATA, PORT_BLK_NUM, PORT_BLK_DATA,
            PORT_BLK_READ, PORT_BLK_PUT, PORT_BLK_WRITE, PORT_TIMER, PORT_TIMER, 8'd0, 8'd4};
        logic [7:0] rports [10] = '{PORT_SER_DATA, PORT_SER_COUNT, PORT_TEXT_DATA,
            PORT_KEY_DATA, PORT_KEY_COUNT, PORT_BLK_DATA, PORT_BLK_READ, PORT_BLK_WRITE,
            8'd0, 8'd200};
        v = 16'($urandom);
        sym = 31'($urandom);
        k = $urandom_range(0, 19);
        if (k < 8) op = OP_WRITE;
        else if (k < 12) op = OP_READ;
        else if (k < 14) op = OP_KEY;
        else if (k < 16) op = OP_SERIAL;
        else if (k < 19) op = OP_TICK;
        else op = 3'($urandom_range(5, 7));
        p = ($urandom_range(0, 15) == 0) ? 8'($urandom) :
            (op == OP_READ ? rports[$urandom_range(0, 9)] : wports[$urandom_range(0, 14)]);
        if (op == OP_WRITE && p == PORT_TIMER) v = 16'($urandom_range(0, 20));
        if (op == OP_WRITE && p == PORT_TEXT_ADDR && $urandom_range(0, 1))
            v[10:0] = 11'($urandom_range(0, 31));
        if (op == OP_KEY && $urandom_range(0, 3) == 0)
            sym = (k & 1) ? KEY_SYM_SHIFT : KEY_SYM_ENTER;
        // guard reads and pointer moves against unwritten entries
        if (op == OP_READ && p == PORT_KEY_DATA && keys_held == 0) p = PORT_KEY_COUNT;
        if (op == OP_READ && p == PORT_SER_DATA && ser_held == 0) p = PORT_SER_COUNT;
        if (op == OP_WRITE && p == PORT_SER_DATA && ser_held <= 1) p = PORT_SER_TX;
        if (op == OP_READ && p == PORT_BLK_DATA && !blk_written[blk_ptr_tb]) p = PORT_BLK_READ;
        if (op == OP_KEY && keys_held >= 250) op = OP_TICK;
        if (op == OP_SERIAL && ser_held >= 250) op = OP_TICK;
        if (op == OP_KEY) keys_held++;
        if (op == OP_SERIAL) ser_held++;
        if (op == OP_READ && p == PORT_KEY_DATA) keys_held--;
        if (op == OP_WRITE && p == PORT_SER_DATA) ser_held--;
        if (op == OP_WRITE && p == PORT_BLK_PUT) begin
            blk_written[blk_ptr_tb] = 1; blk_ptr_tb++;
        end
        if (op == OP_WRITE && p == PORT_BLK_DATA) blk_ptr_tb++;
        if (op == OP_WRITE && (p == PORT_BLK_READ || p == PORT_BLK_WRITE)) blk_ptr_tb = 0;
        send(op, p, v, sym, 1'($urandom), gap);
    endtask

    task automatic wait_drained();
        in_valid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    initial begin
        int gap;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        // directed: extremes, every port but block data and block put, arrow key remaps, timer
        send(OP_KEY, 0, 0, KEY_SYM_LEFT, 0, 0);
        send(OP_KEY, 0, 0, KEY_SYM_UP, 1, 0);
        send(OP_KEY, 0, 0, KEY_SYM_RIGHT, 0, 0);
        send(OP_KEY, 0, 0, KEY_SYM_DOWN, 0, 0);
        send(OP_KEY, 0, 0, 31'h7fffffff, 1, 0);
        send(OP_READ, PORT_KEY_COUNT, 0, 0, 0, 0);
        repeat (5) send(OP_READ, PORT_KEY_DATA, 16'hffff, 0, 0, 0);
        send(OP_SERIAL, 0, 16'hffff, 0, 0, 0);
        send(OP_READ, PORT_SER_DATA, 0, 0, 0, 0);
        send(OP_READ, PORT_SER_COUNT, 0, 0, 0, 0);
        send(OP_WRITE, PORT_SER_TX, 16'hffff, 0, 0, 0);
        send(OP_WRITE, PORT_TEXT_ADDR, 16'hffff, 0, 0, 0);
        send(OP_WRITE, PORT_TEXT_DATA, 16'h00a5, 0, 0, 0);
        send(OP_READ, PORT_TEXT_DATA, 0, 0, 0, 0);
        send(OP_WRITE, PORT_PIX_ADDR, 16'hffff, 0, 0, 0);
        send(OP_WRITE, PORT_PIX_DATA, 16'h00ff, 0, 0, 0);
        send(OP_WRITE, PORT_BLK_NUM, 16'hffff, 0, 0, 0);
        send(OP_WRITE, PORT_BLK_READ, 0, 0, 0, 0);
        send(OP_WRITE, PORT_BLK_WRITE, 0, 0, 0, 0);
        send(OP_WRITE, PORT_TIMER, 16'd1, 0, 0, 0);
        send(OP_TICK, 0, 0, 0, 0, 0);
        send(3'd7, 8'hff, 16'hffff, 31'h7fffffff, 1, 0);
        // sender pause until drained
        wait_drained();
        // random with idling, one long receiver hold midway
        for (int i = 0; i < 1750; i++) begin
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
            if (i >= 600 && i < 800) gap = 0;
            if (i == 600) long_hold = 1;
            if (i == 1200) wait_drained();
            send_random(gap);
        end
        in_valid <= 0;
        sending_done = 1;
    end

    // end of run
    initial begin
        wait (sending_done);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS port_mapped_io_controller_top");
        else
            $display("FAIL port_mapped_io_controller_top");
        $finish;
    end
endmodule

### sim.f
rtl/core/pmio_pkg.sv
rtl/core/pmio_ram.sv
rtl/core/pmio_fifo.sv
rtl/core/pmio_front.sv
rtl/core/pmio_back.sv
rtl/core/port_mapped_io_controller_top.sv
verif/tb.sv
